// ===== sv/owts_pkg.sv =====
// Package for the one-wire temperature sensor master.
// Holds the sequencer phases, codes, register defaults and the shared structs.
// No dependencies.
`default_nettype none

package owts_pkg;

    // Bus sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_RECOVER,
        PH_SLOT_START,
        PH_SLOT_ZERO,
        PH_SLOT_SAMPLE,
        PH_SLOT_HOLD,
        PH_SLOT_RECOVER
    } t_phase;

    // Action codes of an input word
    localparam logic [2:0] ACT_TICK    = 3'd0;
    localparam logic [2:0] ACT_SET_RES = 3'd1;
    localparam logic [2:0] ACT_CONVERT = 3'd2;
    localparam logic [2:0] ACT_POLL    = 3'd3;
    localparam logic [2:0] ACT_READ    = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BAD_RES     = 2'd1;
    localparam logic [1:0] ST_NO_PRESENCE = 2'd2;

    // Bus command bytes
    localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
    localparam logic [7:0] CMD_WRITE_PAD = 8'h4E;
    localparam logic [7:0] CMD_CONVERT   = 8'h44;
    localparam logic [7:0] CMD_READ_PAD  = 8'hBE;

    // Legal resolution range
    localparam logic [3:0] RES_MIN = 4'd9;
    localparam logic [3:0] RES_MAX = 4'd12;

    // Configuration port geometry and register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW_TIME = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_RECOVER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DELAY   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_HOLD    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY       = 3'd7;

    // Register reset values
    localparam logic [9:0] DEF_RESET_LOW_TIME = 10'd480;
    localparam logic [7:0] DEF_PRESENCE_WAIT  = 8'd64;
    localparam logic [9:0] DEF_RESET_RECOVER  = 10'd416;
    localparam logic [3:0] DEF_START_LOW      = 4'd2;
    localparam logic [5:0] DEF_SAMPLE_DELAY   = 6'd10;
    localparam logic [6:0] DEF_SAMPLE_HOLD    = 7'd50;
    localparam logic [6:0] DEF_ZERO_LOW       = 7'd60;
    localparam logic [5:0] DEF_RECOVERY       = 6'd2;

    // Timing registers as seen by the sequencer
    typedef struct packed {
        logic [9:0] reset_low_time;
        logic [7:0] presence_wait;
        logic [9:0] reset_recover;
        logic [3:0] start_low;
        logic [5:0] sample_delay;
        logic [6:0] sample_hold;
        logic [6:0] zero_low;
        logic [5:0] recovery;
    } t_cfg;

    // One result word
    typedef struct packed {
        logic               drive_low;
        logic               busy_res;
        logic               done_res;
        logic [1:0]         status;
        logic               ready_bit;
        logic signed [15:0] raw_temperature;
        logic signed [11:0] whole_degrees;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/owts_ifs.sv =====
// Channel interfaces of the one-wire temperature sensor master.
// Depends on owts_pkg for the configuration port widths.
`default_nettype none

interface owts_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [3:0] resolution;
    logic       line_level;

    modport source (output valid, action, resolution, line_level, input ready);
    modport sink   (input valid, action, resolution, line_level, output ready);
endinterface

interface owts_out_if;
    logic               valid;
    logic               ready;
    logic               drive_low;
    logic               busy_res;
    logic               done_res;
    logic [1:0]         status;
    logic               ready_bit;
    logic signed [15:0] raw_temperature;
    logic signed [11:0] whole_degrees;

    modport source (output valid, drive_low, busy_res, done_res, status, ready_bit,
                    raw_temperature, whole_degrees, input ready);
    modport sink   (input valid, drive_low, busy_res, done_res, status, ready_bit,
                    raw_temperature, whole_degrees, output ready);
endinterface

interface owts_cfg_if
    import owts_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/onewire_temp_sensor_master.sv =====
// Top level of the one-wire temperature sensor master.
// Depends on owts_pkg, owts_ifs, owts_cfg, owts_seq and owts_obuf.
//
//   port      dir  words carried
//   i_item    in   one microsecond tick: action, resolution, line_level
//   o_result  out  one result per tick: drive, flags, status, temperature
//   i_cfg     in   timing register writes: index, data
//
// One tick word is accepted every cycle while the output is not stalled; each result
// passes through the input register, then the two-word result buffer.
// The bus sequencer's state update, committed as each word moves on, sets this rate.
// Reset is synchronous and active low; it restores the timing defaults and
// clears the sequencer and results. A stalled output fills the result buffer,
// then holds the input register and drops i_item.ready.
`default_nettype none

module onewire_temp_sensor_master
    import owts_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    owts_in_if.sink     i_item,
    owts_out_if.source  o_result,
    owts_cfg_if.sink    i_cfg
);

    t_cfg    cfg;
    t_result result;
    logic    push;
    logic    space;

    owts_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    owts_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_item   (i_item),
        .i_space  (space),
        .o_push   (push),
        .o_result (result)
    );

    owts_obuf u_obuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (result),
        .o_space  (space),
        .o_res    (o_result)
    );

endmodule

`default_nettype wire

// ===== sv/owts_cfg.sv =====
// Timing register file of the one-wire temperature sensor master.
// Depends on owts_pkg and owts_cfg_if.
`default_nettype none

module owts_cfg
    import owts_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    owts_cfg_if.sink  i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;
    logic wr_en;

    // Always take a write
    assign i_cfg.ready = 1'b1;
    assign wr_en       = i_cfg.valid && i_cfg.ready;

    // Store the written register, masked to its width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_time <= DEF_RESET_LOW_TIME;
            r_cfg.presence_wait  <= DEF_PRESENCE_WAIT;
            r_cfg.reset_recover  <= DEF_RESET_RECOVER;
            r_cfg.start_low      <= DEF_START_LOW;
            r_cfg.sample_delay   <= DEF_SAMPLE_DELAY;
            r_cfg.sample_hold    <= DEF_SAMPLE_HOLD;
            r_cfg.zero_low       <= DEF_ZERO_LOW;
            r_cfg.recovery       <= DEF_RECOVERY;
        end else if (wr_en) begin
            case (i_cfg.index)
                CFG_RESET_LOW_TIME: r_cfg.reset_low_time <= i_cfg.data[9:0];
                CFG_PRESENCE_WAIT:  r_cfg.presence_wait  <= i_cfg.data[7:0];
                CFG_RESET_RECOVER:  r_cfg.reset_recover  <= i_cfg.data[9:0];
                CFG_START_LOW:      r_cfg.start_low      <= i_cfg.data[3:0];
                CFG_SAMPLE_DELAY:   r_cfg.sample_delay   <= i_cfg.data[5:0];
                CFG_SAMPLE_HOLD:    r_cfg.sample_hold    <= i_cfg.data[6:0];
                CFG_ZERO_LOW:       r_cfg.zero_low       <= i_cfg.data[6:0];
                CFG_RECOVERY:       r_cfg.recovery       <= i_cfg.data[5:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== sv/owts_seq.sv =====
// Bus sequencer of the one-wire temperature sensor master: input register,
// one-tick state update and result formation. Depends on owts_pkg, owts_in_if.
`default_nettype none

module owts_seq
    import owts_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    owts_in_if.sink   i_item,
    input  wire logic i_space,
    output logic      o_push,
    output t_result   o_result
);

    // Input register
    logic       r_in_valid;
    logic [2:0] r_action;
    logic [3:0] r_resolution;
    logic       r_line;

    // Sequencer state
    t_phase     r_phase,    n_phase;
    logic [9:0] r_time,     n_time;
    logic [2:0] r_bit_cnt,  n_bit_cnt;
    logic [7:0] r_shift,    n_shift;
    logic [2:0] r_step,     n_step;
    logic [2:0] r_cmd,      n_cmd;
    logic [15:0] r_temp,    n_temp;
    logic [3:0] r_res_use,  n_res_use;
    logic [1:0] r_status,   n_status;
    logic       r_ready,    n_ready;
    logic [3:0] r_pend_res, n_pend_res;
    logic       r_perr,     n_perr;
    logic       r_slot_bit, n_slot_bit;
    logic       r_reading,  n_reading;

    logic        n_done;
    logic        drive;
    logic        do_next;
    logic [7:0]  shifted;
    logic [3:0]  res_off;
    logic signed [15:0] quot;
    logic        round_up;

    // Phase length; a zero register counts as one microsecond
    function automatic logic [9:0] phase_time(input t_phase ph, input t_cfg c);
        logic [9:0] v;
        case (ph)
            PH_RST_LOW:      v = c.reset_low_time;
            PH_RST_WAIT:     v = {2'b0, c.presence_wait};
            PH_RST_RECOVER:  v = c.reset_recover;
            PH_SLOT_START:   v = {6'b0, c.start_low};
            PH_SLOT_ZERO:    v = {3'b0, c.zero_low};
            PH_SLOT_SAMPLE:  v = {4'b0, c.sample_delay};
            PH_SLOT_HOLD:    v = {3'b0, c.sample_hold};
            PH_SLOT_RECOVER: v = {4'b0, c.recovery};
            default:         v = 10'd0;
        endcase
        return (v == 10'd0) ? 10'd1 : v;
    endfunction

    // Advance the input register when the result can be handed on
    assign o_push       = r_in_valid && i_space;
    assign i_item.ready = !r_in_valid || o_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_action     <= i_item.action;
            r_resolution <= i_item.resolution;
            r_line       <= i_item.line_level;
        end
    end

    // One microsecond of bus sequencing
    always_comb begin
        n_phase    = r_phase;
        n_time     = r_time;
        n_bit_cnt  = r_bit_cnt;
        n_shift    = r_shift;
        n_step     = r_step;
        n_cmd      = r_cmd;
        n_temp     = r_temp;
        n_res_use  = r_res_use;
        n_status   = r_status;
        n_ready    = r_ready;
        n_pend_res = r_pend_res;
        n_perr     = r_perr;
        n_slot_bit = r_slot_bit;
        n_reading  = r_reading;
        n_done     = 1'b0;
        drive      = 1'b0;
        do_next    = 1'b0;
        shifted    = 8'd0;
        res_off    = 4'd0;

        // Take a command when idle
        if (r_phase == PH_IDLE && r_action >= ACT_SET_RES && r_action <= ACT_READ) begin
            if (r_action == ACT_SET_RES &&
                (r_resolution < RES_MIN || r_resolution > RES_MAX)) begin
                n_status = ST_BAD_RES;
                n_done   = 1'b1;
                n_phase  = PH_IDLE;
                n_time   = 10'd0;
            end else begin
                n_cmd      = r_action;
                n_pend_res = r_resolution;
                n_step     = 3'd0;
                n_perr     = 1'b0;
                if (r_action == ACT_POLL) begin
                    n_reading  = 1'b1;
                    n_slot_bit = 1'b1;
                    n_phase    = PH_SLOT_START;
                end else begin
                    n_phase = PH_RST_LOW;
                end
                n_time = phase_time(n_phase, i_cfg);
            end
        end

        // Count down the current phase and move on at its end
        if (n_phase != PH_IDLE) begin
            drive  = (n_phase == PH_RST_LOW) || (n_phase == PH_SLOT_START) ||
                     (n_phase == PH_SLOT_ZERO);
            n_time = n_time - 10'd1;
            if (n_time == 10'd0) begin
                case (n_phase)
                    PH_RST_LOW: begin
                        n_phase = PH_RST_WAIT;
                        n_time  = phase_time(PH_RST_WAIT, i_cfg);
                    end
                    PH_RST_WAIT: begin
                        n_perr  = r_line;
                        n_phase = PH_RST_RECOVER;
                        n_time  = phase_time(PH_RST_RECOVER, i_cfg);
                    end
                    PH_RST_RECOVER: begin
                        if (n_perr || !r_line) begin
                            n_status = ST_NO_PRESENCE;
                            n_done   = 1'b1;
                            n_phase  = PH_IDLE;
                            n_time   = 10'd0;
                        end else begin
                            n_step  = 3'd0;
                            do_next = 1'b1;
                        end
                    end
                    PH_SLOT_START: begin
                        n_phase = n_slot_bit ? PH_SLOT_SAMPLE : PH_SLOT_ZERO;
                        n_time  = phase_time(n_phase, i_cfg);
                    end
                    PH_SLOT_ZERO, PH_SLOT_HOLD: begin
                        n_phase = PH_SLOT_RECOVER;
                        n_time  = phase_time(PH_SLOT_RECOVER, i_cfg);
                    end
                    PH_SLOT_SAMPLE: begin
                        n_slot_bit = r_line;
                        n_phase    = PH_SLOT_HOLD;
                        n_time     = phase_time(PH_SLOT_HOLD, i_cfg);
                    end
                    PH_SLOT_RECOVER: begin
                        if (n_cmd == ACT_POLL) begin
                            // Poll ends after its single read slot
                            n_ready  = n_slot_bit;
                            n_status = ST_OK;
                            n_done   = 1'b1;
                            n_phase  = PH_IDLE;
                            n_time   = 10'd0;
                        end else begin
                            shifted   = n_reading ? {n_slot_bit, n_shift[7:1]}
                                                  : {1'b0, n_shift[7:1]};
                            n_shift   = shifted;
                            n_bit_cnt = n_bit_cnt + 3'd1;
                            if (n_bit_cnt != 3'd0) begin
                                n_slot_bit = n_reading ? 1'b1 : shifted[0];
                                n_phase    = PH_SLOT_START;
                                n_time     = phase_time(PH_SLOT_START, i_cfg);
                            end else begin
                                // Byte complete: store read data, go to next byte
                                if (n_reading) begin
                                    if (n_step == 3'd2) begin
                                        n_temp[7:0] = shifted;
                                    end else begin
                                        n_temp[15:8] = shifted;
                                    end
                                end
                                n_step  = n_step + 3'd1;
                                do_next = 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        n_time  = 10'd0;
                    end
                endcase
            end
        end

        // Pick the next byte of the command, or finish
        if (do_next) begin
            res_off = n_pend_res - RES_MIN;
            n_bit_cnt = 3'd0;
            n_phase   = PH_SLOT_START;
            n_time    = phase_time(PH_SLOT_START, i_cfg);
            n_reading = 1'b0;
            if (n_step == 3'd0) begin
                n_shift = CMD_SKIP_ROM;
            end else if (n_cmd == ACT_SET_RES) begin
                case (n_step)
                    3'd1:       n_shift = CMD_WRITE_PAD;
                    3'd2, 3'd3: n_shift = 8'h00;
                    3'd4:       n_shift = {1'b0, res_off[1:0], 5'b0};
                    default: begin
                        n_res_use = n_pend_res;
                        n_phase   = PH_IDLE;
                    end
                endcase
            end else if (n_cmd == ACT_CONVERT) begin
                if (n_step == 3'd1) begin
                    n_shift = CMD_CONVERT;
                end else begin
                    n_phase = PH_IDLE;
                end
            end else begin
                case (n_step)
                    3'd1: n_shift = CMD_READ_PAD;
                    3'd2, 3'd3: begin
                        n_shift   = 8'h00;
                        n_reading = 1'b1;
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
            if (n_phase == PH_IDLE) begin
                // Command complete
                n_reading = r_reading;
                n_shift   = shifted;
                n_status  = ST_OK;
                n_done    = 1'b1;
                n_time    = 10'd0;
            end else begin
                n_slot_bit = n_reading ? 1'b1 : n_shift[0];
            end
        end
    end

    // Commit the state when the word moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_time     <= 10'd0;
            r_bit_cnt  <= 3'd0;
            r_shift    <= 8'd0;
            r_step     <= 3'd0;
            r_cmd      <= 3'd0;
            r_temp     <= 16'd0;
            r_res_use  <= 4'd0;
            r_status   <= ST_OK;
            r_ready    <= 1'b0;
            r_pend_res <= 4'd0;
            r_perr     <= 1'b0;
            r_slot_bit <= 1'b0;
            r_reading  <= 1'b0;
        end else if (o_push) begin
            r_phase    <= n_phase;
            r_time     <= n_time;
            r_bit_cnt  <= n_bit_cnt;
            r_shift    <= n_shift;
            r_step     <= n_step;
            r_cmd      <= n_cmd;
            r_temp     <= n_temp;
            r_res_use  <= n_res_use;
            r_status   <= n_status;
            r_ready    <= n_ready;
            r_pend_res <= n_pend_res;
            r_perr     <= n_perr;
            r_slot_bit <= n_slot_bit;
            r_reading  <= n_reading;
        end
    end

    // Whole degrees: shift, then round toward zero for negative values
    assign quot     = $signed(n_temp) >>> 4;
    assign round_up = n_temp[15] && (n_temp[3:0] != 4'd0);

    always_comb begin
        o_result.drive_low       = drive;
        o_result.busy_res        = (n_phase != PH_IDLE);
        o_result.done_res        = n_done;
        o_result.status          = n_status;
        o_result.ready_bit       = n_ready;
        o_result.raw_temperature = $signed(n_temp);
        o_result.whole_degrees   = $signed(quot[11:0] + {11'd0, round_up});
    end

endmodule

`default_nettype wire

// ===== sv/owts_obuf.sv =====
// Two-word result buffer of the one-wire temperature sensor master.
// Depends on owts_pkg and owts_out_if.
`default_nettype none

module owts_obuf
    import owts_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_result,
    output logic      o_space,
    owts_out_if.source o_res
);

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;
    t_result    head;

    assign pop     = o_res.valid && o_res.ready;
    assign o_space = (r_count != 2'd2) || pop;

    // Store a pushed word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_result;
        end
    end

    // Track fill level and pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Present the oldest word
    assign head                  = r_mem[r_rd_ptr];
    assign o_res.valid           = (r_count != 2'd0);
    assign o_res.drive_low       = head.drive_low;
    assign o_res.busy_res        = head.busy_res;
    assign o_res.done_res        = head.done_res;
    assign o_res.status          = head.status;
    assign o_res.ready_bit       = head.ready_bit;
    assign o_res.raw_temperature = head.raw_temperature;
    assign o_res.whole_degrees   = head.whole_degrees;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Testbench for the one-wire temperature sensor master.
// Depends on owts_pkg, owts_ifs and the onewire_temp_sensor_master RTL; a sensor
// emulation answers the bus and a per-tick predictor checks every result word.
`default_nettype none

module tb;
    import owts_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int ITEM_TARGET = 650;

    // How the emulated sensor answers on the line
    typedef enum logic [1:0] {
        SENSE_CLEAN,
        SENSE_ABSENT,
        SENSE_STUCK_LOW,
        SENSE_NOISY
    } t_sense;

    logic i_clk = 1'b0;
    logic i_rst_n;

    owts_in_if  item_ch();
    owts_out_if result_ch();
    owts_cfg_if cfg_ch();

    onewire_temp_sensor_master u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    always #6 i_clk = ~i_clk;

    // Bus master state as predicted tick by tick
    logic [9:0]  tmg [8];
    logic [9:0]  tmg_plan [8];
    t_phase      bus_phase;
    logic [9:0]  slot_time;
    logic [2:0]  bits_done;
    logic [7:0]  shift_q;
    logic [2:0]  byte_idx;
    logic [2:0]  active_cmd;
    logic [15:0] temp_q;
    logic [3:0]  res_active;
    logic [1:0]  status_q;
    logic        ready_q;
    logic [3:0]  res_pending;
    logic        presence_bad;
    logic        slot_bit;
    logic        reading_byte;
    logic        done_now;

    t_result     tick_reports_q[$];
    int          fail_count = 0;
    int          sent_count = 0;
    int          burst_left = 0;
    bit          steady = 1'b0;
    t_sense      sense_mode = SENSE_CLEAN;
    logic [15:0] sensor_temp = '0;

    // Predictor
    function automatic void reset_predictor();
        tmg[CFG_RESET_LOW_TIME] = 10'(DEF_RESET_LOW_TIME);
        tmg[CFG_PRESENCE_WAIT]  = 10'(DEF_PRESENCE_WAIT);
        tmg[CFG_RESET_RECOVER]  = 10'(DEF_RESET_RECOVER);
        tmg[CFG_START_LOW]      = 10'(DEF_START_LOW);
        tmg[CFG_SAMPLE_DELAY]   = 10'(DEF_SAMPLE_DELAY);
        tmg[CFG_SAMPLE_HOLD]    = 10'(DEF_SAMPLE_HOLD);
        tmg[CFG_ZERO_LOW]       = 10'(DEF_ZERO_LOW);
        tmg[CFG_RECOVERY]       = 10'(DEF_RECOVERY);
        bus_phase = PH_IDLE;
        slot_time = '0;
        bits_done = '0;
        shift_q = '0;
        byte_idx = '0;
        active_cmd = '0;
        temp_q = '0;
        res_active = '0;
        status_q = ST_OK;
        ready_q = 1'b0;
        res_pending = '0;
        presence_bad = 1'b0;
        slot_bit = 1'b0;
        reading_byte = 1'b0;
        done_now = 1'b0;
    endfunction

    function automatic logic [9:0] reg_mask(logic [2:0] idx);
        case (idx)
            CFG_PRESENCE_WAIT:              return 10'h0FF;
            CFG_START_LOW:                  return 10'h00F;
            CFG_SAMPLE_DELAY, CFG_RECOVERY: return 10'h03F;
            CFG_SAMPLE_HOLD, CFG_ZERO_LOW:  return 10'h07F;
            default:                        return 10'h3FF;
        endcase
    endfunction

    // A zero length still lasts one microsecond
    function automatic void enter_phase(t_phase p, logic [2:0] idx);
        bus_phase = p;
        slot_time = (tmg[idx] == '0) ? 10'd1 : tmg[idx];
    endfunction

    function automatic void end_command(logic [1:0] st);
        status_q = st;
        done_now = 1'b1;
        bus_phase = PH_IDLE;
        slot_time = '0;
    endfunction

    function automatic void begin_slot(logic b);
        slot_bit = b;
        enter_phase(PH_SLOT_START, CFG_START_LOW);
    endfunction

    function automatic void write_byte(logic [7:0] v);
        shift_q = v;
        bits_done = '0;
        reading_byte = 1'b0;
        begin_slot(v[0]);
    endfunction

    function automatic void read_byte();
        shift_q = '0;
        bits_done = '0;
        reading_byte = 1'b1;
        begin_slot(1'b1);
    endfunction

    // Pick the next byte of the command, or close it
    function automatic void next_bus_byte();
        logic [3:0] code;
        code = res_pending - RES_MIN;
        if (byte_idx == 3'd0) begin
            write_byte(CMD_SKIP_ROM);
        end else if (active_cmd == ACT_SET_RES) begin
            case (byte_idx)
                3'd1:       write_byte(CMD_WRITE_PAD);
                3'd2, 3'd3: write_byte(8'h00);
                3'd4:       write_byte({1'b0, code[1:0], 5'b0});
                default: begin
                    res_active = res_pending;
                    end_command(ST_OK);
                end
            endcase
        end else if (active_cmd == ACT_CONVERT) begin
            if (byte_idx == 3'd1) write_byte(CMD_CONVERT);
            else end_command(ST_OK);
        end else begin
            case (byte_idx)
                3'd1:       write_byte(CMD_READ_PAD);
                3'd2, 3'd3: read_byte();
                default:    end_command(ST_OK);
            endcase
        end
    endfunction

    // Shift the finished slot, then start the next slot or byte
    function automatic void slot_finished();
        if (active_cmd == ACT_POLL) begin
            ready_q = slot_bit;
            end_command(ST_OK);
            return;
        end
        if (reading_byte) shift_q = {slot_bit, shift_q[7:1]};
        else shift_q = shift_q >> 1;
        bits_done = bits_done + 3'd1;
        if (bits_done != 3'd0) begin
            begin_slot(reading_byte ? 1'b1 : shift_q[0]);
            return;
        end
        if (reading_byte) begin
            if (byte_idx == 3'd2) temp_q[7:0] = shift_q;
            else temp_q[15:8] = shift_q;
        end
        byte_idx = byte_idx + 3'd1;
        next_bus_byte();
    endfunction

    function automatic t_result sequence_tick(logic [2:0] act, logic [3:0] res, logic line);
        t_result r;
        int      whole;
        done_now = 1'b0;
        r.drive_low = 1'b0;
        // Take a command only when idle
        if (bus_phase == PH_IDLE && act >= ACT_SET_RES && act <= ACT_READ) begin
            if (act == ACT_SET_RES && (res < RES_MIN || res > RES_MAX)) begin
                end_command(ST_BAD_RES);
            end else begin
                active_cmd = act;
                res_pending = res;
                byte_idx = '0;
                presence_bad = 1'b0;
                if (act == ACT_POLL) begin
                    reading_byte = 1'b1;
                    begin_slot(1'b1);
                end else begin
                    enter_phase(PH_RST_LOW, CFG_RESET_LOW_TIME);
                end
            end
        end
        // Advance the running phase by one microsecond
        if (bus_phase != PH_IDLE) begin
            r.drive_low = (bus_phase == PH_RST_LOW || bus_phase == PH_SLOT_START ||
                           bus_phase == PH_SLOT_ZERO);
            slot_time = slot_time - 10'd1;
            if (slot_time == '0) begin
                case (bus_phase)
                    PH_RST_LOW: enter_phase(PH_RST_WAIT, CFG_PRESENCE_WAIT);
                    PH_RST_WAIT: begin
                        presence_bad = line;
                        enter_phase(PH_RST_RECOVER, CFG_RESET_RECOVER);
                    end
                    PH_RST_RECOVER: begin
                        if (presence_bad || !line) begin
                            end_command(ST_NO_PRESENCE);
                        end else begin
                            byte_idx = '0;
                            next_bus_byte();
                        end
                    end
                    PH_SLOT_START: begin
                        if (slot_bit) enter_phase(PH_SLOT_SAMPLE, CFG_SAMPLE_DELAY);
                        else enter_phase(PH_SLOT_ZERO, CFG_ZERO_LOW);
                    end
                    PH_SLOT_ZERO: enter_phase(PH_SLOT_RECOVER, CFG_RECOVERY);
                    PH_SLOT_SAMPLE: begin
                        slot_bit = line;
                        enter_phase(PH_SLOT_HOLD, CFG_SAMPLE_HOLD);
                    end
                    PH_SLOT_HOLD: enter_phase(PH_SLOT_RECOVER, CFG_RECOVERY);
                    PH_SLOT_RECOVER: slot_finished();
                    default: begin
                        bus_phase = PH_IDLE;
                        slot_time = '0;
                    end
                endcase
            end
        end
        whole = $signed(temp_q);
        whole = whole / 16;
        r.busy_res = (bus_phase != PH_IDLE);
        r.done_res = done_now;
        r.status = status_q;
        r.ready_bit = ready_q;
        r.raw_temperature = temp_q;
        r.whole_degrees = whole[11:0];
        return r;
    endfunction

    // Sensor emulation: line level for the tick about to be sent
    function automatic logic bus_line_level();
        if (sense_mode == SENSE_NOISY) return 1'($urandom_range(0, 1));
        case (bus_phase)
            PH_RST_WAIT:    return (sense_mode == SENSE_ABSENT);
            PH_RST_RECOVER: return (sense_mode != SENSE_STUCK_LOW);
            PH_SLOT_SAMPLE: begin
                if (active_cmd == ACT_READ && reading_byte)
                    return sensor_temp[{byte_idx == 3'd3, bits_done}];
                if (active_cmd == ACT_POLL) return sensor_temp[0];
                return 1'b1;
            end
            PH_RST_LOW, PH_SLOT_START, PH_SLOT_ZERO: return 1'b0;
            default: return 1'b1;
        endcase
    endfunction

    // Send one tick word in bursts, with random gaps after all but steady bursts, then predict it
    task automatic send_tick(input logic [2:0] act, input logic [3:0] res);
        logic line;
        if (burst_left == 0) begin
            if (!steady) begin
                item_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            steady = ($urandom_range(0, 9) == 0);
            burst_left = steady ? 200 : $urandom_range(1, 40);
        end
        burst_left--;
        line = bus_line_level();
        item_ch.valid      <= 1'b1;
        item_ch.action     <= act;
        item_ch.resolution <= res;
        item_ch.line_level <= line;
        do @(posedge i_clk); while (!item_ch.ready);
        sent_count++;
        tick_reports_q.push_back(sequence_tick(act, res, line));
    endtask

    // Issue one command and tick until the sequence ends
    task automatic run_command(input logic [2:0] act, input logic [3:0] res,
                               input t_sense mode, input logic [15:0] temp);
        int pick;
        sense_mode = mode;
        sensor_temp = temp;
        send_tick(act, res);
        while (bus_phase != PH_IDLE) begin
            // stray commands while busy must be dropped
            if ($urandom_range(0, 7) == 0) send_tick(3'($urandom_range(0, 7)), 4'($urandom));
            else send_tick(ACT_TICK, 4'($urandom));
        end
        repeat ($urandom_range(0, 3)) begin
            pick = $urandom_range(0, 3);
            // codes above read act as plain ticks
            send_tick(pick == 0 ? ACT_TICK : 3'(ACT_READ + pick), 4'($urandom));
        end
    endtask

    // Hold off until every word is back and the block is quiet
    task automatic drain();
        item_ch.valid <= 1'b0;
        burst_left = 0;
        while (tick_reports_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_timing();
        drain();
        for (int i = 0; i < 8; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= 3'(i);
            cfg_ch.data  <= tmg_plan[i];
            do @(posedge i_clk); while (!cfg_ch.ready);
            tmg[i] = tmg_plan[i] & reg_mask(3'(i));
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Tests
    task automatic test_default_timing();
        run_command(ACT_POLL, 4'd0, SENSE_CLEAN, 16'h0001);
        run_command(ACT_SET_RES, 4'd8, SENSE_CLEAN, 16'h0000);
    endtask

    task automatic test_command_set();
        tmg_plan = '{10'd2, 10'd1, 10'd2, 10'd2, 10'd1, 10'd2, 10'd1, 10'd1};
        load_timing();
        // out-of-range resolutions finish at once
        run_command(ACT_SET_RES, 4'd0, SENSE_CLEAN, 16'h0000);
        run_command(ACT_SET_RES, 4'd13, SENSE_CLEAN, 16'h0000);
        run_command(ACT_SET_RES, 4'd15, SENSE_CLEAN, 16'h0000);
        run_command(ACT_POLL, 4'd0, SENSE_CLEAN, 16'h0000);
        run_command(ACT_POLL, 4'd0, SENSE_CLEAN, 16'h0001);
        run_command(ACT_CONVERT, 4'd0, SENSE_CLEAN, 16'h0000);
        // reset fault leaves everything but the status alone
        run_command(ACT_CONVERT, 4'd0, SENSE_ABSENT, 16'h0000);
    endtask

    task automatic test_zero_timing();
        tmg_plan = '{default: 10'd0};
        load_timing();
        // negative value checks truncation toward zero
        run_command(ACT_READ, 4'd0, SENSE_CLEAN, 16'hFFEF);
        run_command(ACT_SET_RES, 4'd12, SENSE_CLEAN, 16'h0000);
        run_command(ACT_READ, 4'd0, SENSE_STUCK_LOW, 16'h1234);
    endtask

    // Upper bits of narrow registers are dropped, leaving the slot phases at zero
    task automatic test_register_width();
        tmg_plan = '{default: 10'h380};
        load_timing();
        run_command(ACT_POLL, 4'd0, SENSE_CLEAN, 16'h0001);
    endtask

    task automatic test_random_traffic();
        int         pick;
        int         cmds;
        logic [2:0] act;
        logic [3:0] res;
        t_sense     mode;
        cmds = 0;
        // stop with room left for the last command
        while (sent_count + 60 < ITEM_TARGET) begin
            if (cmds % 3 == 0) begin
                for (int i = 0; i < 8; i++)
                    tmg_plan[i] = 10'($urandom_range(0,
                        (i == CFG_RESET_LOW_TIME || i == CFG_RESET_RECOVER) ? 3 : 1));
                load_timing();
            end
            cmds++;
            pick = $urandom_range(0, 19);
            if (pick < 6) act = ACT_READ;
            else if (pick < 10) act = ACT_CONVERT;
            else if (pick < 14) act = ACT_SET_RES;
            else act = ACT_POLL;
            res = ($urandom_range(0, 3) == 0) ? 4'($urandom)
                                              : 4'($urandom_range(RES_MIN, RES_MAX));
            pick = $urandom_range(0, 19);
            mode = (pick == 0) ? SENSE_ABSENT :
                   (pick == 1) ? SENSE_STUCK_LOW :
                   (pick == 2) ? SENSE_NOISY : SENSE_CLEAN;
            run_command(act, res, mode, 16'($urandom));
        end
    endtask

    // Result receiver: stall pattern with a new mode and hold picked whenever rx_count[7:0] wraps to zero
    logic [15:0] rx_count = '0;
    logic [1:0]  rx_mode = '0;
    logic [3:0]  rx_hold = 4'd4;

    always @(posedge i_clk) begin
        rx_count <= rx_count + 16'd1;
        if (rx_count[7:0] == 8'd0) begin
            rx_mode <= 2'($urandom_range(0, 2));
            rx_hold <= 4'($urandom_range(1, 10));
        end
        case (rx_mode)
            2'd0:    result_ch.ready <= 1'b1;
            2'd1:    result_ch.ready <= ($urandom_range(0, 3) != 0);
            default: result_ch.ready <= (rx_count[3:0] >= rx_hold);
        endcase
    end

    // Compare each result word with the oldest prediction
    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (tick_reports_q.size() == 0) begin
                $display("%0t result word with no tick pending: expected none actual %h",
                         $time, result_ch.raw_temperature);
                fail_count++;
            end else begin
                want = tick_reports_q.pop_front();
                check_field("drive_low", 16'(want.drive_low), 16'(result_ch.drive_low));
                check_field("busy_res", 16'(want.busy_res), 16'(result_ch.busy_res));
                check_field("done_res", 16'(want.done_res), 16'(result_ch.done_res));
                check_field("status", 16'(want.status), 16'(result_ch.status));
                check_field("ready_bit", 16'(want.ready_bit), 16'(result_ch.ready_bit));
                check_field("raw_temperature", want.raw_temperature,
                            result_ch.raw_temperature);
                check_field("whole_degrees", 16'(want.whole_degrees),
                            16'(result_ch.whole_degrees));
            end
        end
    end

    // Watchdog: count cycles with no word moving on any channel
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (item_ch.valid && item_ch.ready) ||
            (result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n            <= 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.action     <= ACT_TICK;
        item_ch.resolution <= '0;
        item_ch.line_level <= 1'b1;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= CFG_RESET_LOW_TIME;
        cfg_ch.data        <= '0;
        reset_predictor();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_timing();
        test_command_set();
        test_zero_timing();
        test_register_width();
        test_random_traffic();

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
